### src/gsa_pkg.sv
`timescale 1ns / 1ps

package gsa_pkg;

  // control sideband that travels with every pipeline stage
  typedef struct packed {
    logic valid;
    logic last;
    logic neg;
  } ctrl_t;

  // activation select codes for the mode register
  localparam logic MODE_GELU = 1'b0;
  localparam logic MODE_SILU = 1'b1;

  localparam int unsigned ARG_W  = 39;  // |t| in Q.32, clamped to 64
  localparam int unsigned K_W    = 7;
  localparam int unsigned R_W    = 32;
  localparam int unsigned TERM_W = 33;
  localparam int unsigned SUM_W  = 35;
  localparam int unsigned E_W    = 33;  // exp(-|t|) in Q.32
  localparam int unsigned SIG_W  = 32;  // sigmoid in Q.31
  localparam int unsigned XQ_W   = 29;  // gelu |x| in Q.24
  localparam int unsigned X2_W   = 33;
  localparam int unsigned F_W    = 30;
  localparam int unsigned TG_W   = 42;

  localparam logic [R_W-1:0]   LN2_Q32 = 32'd2977044472;
  localparam logic [E_W-1:0]   ONE_Q32 = 33'h1_0000_0000;
  localparam logic [28:0]      C2_Q32  = 29'd306466602;
  localparam logic [F_W-1:0]   C1_Q24  = 30'((64'd6853776189 + 64'd128) >> 8);
  localparam logic [16:0]      K_RECIP = 17'((64'd1 << 48) / 64'd2977044472);
  localparam logic [ARG_W-1:0] T_MAX   = 39'h40_0000_0000;
  localparam logic [K_W-1:0]   K_LIMIT = 7'd40;

  localparam int unsigned EXP_TERMS = 16;

  // floor(2^34 / n) for the taylor term divisors n = 1 .. 16
  localparam logic [34:0] DIV_MAGIC [EXP_TERMS] = '{
    35'((64'd1 << 34) / 64'd1),  35'((64'd1 << 34) / 64'd2),
    35'((64'd1 << 34) / 64'd3),  35'((64'd1 << 34) / 64'd4),
    35'((64'd1 << 34) / 64'd5),  35'((64'd1 << 34) / 64'd6),
    35'((64'd1 << 34) / 64'd7),  35'((64'd1 << 34) / 64'd8),
    35'((64'd1 << 34) / 64'd9),  35'((64'd1 << 34) / 64'd10),
    35'((64'd1 << 34) / 64'd11), 35'((64'd1 << 34) / 64'd12),
    35'((64'd1 << 34) / 64'd13), 35'((64'd1 << 34) / 64'd14),
    35'((64'd1 << 34) / 64'd15), 35'((64'd1 << 34) / 64'd16)
  };

endpackage

### src/gsa_stream_if.sv
`timescale 1ns / 1ps

interface gsa_in_if #(
  parameter int unsigned DATA_WIDTH = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample;
  logic                         last_in;

  modport source (output valid, sample, last_in, input ready);
  modport sink (input valid, sample, last_in, output ready);
endinterface

interface gsa_out_if #(
  parameter int unsigned DATA_WIDTH = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] activated;
  logic                         last_out;

  modport source (output valid, activated, last_out, input ready);
  modport sink (input valid, activated, last_out, output ready);
endinterface

### src/gsa_arg.sv
`timescale 1ns / 1ps

module gsa_arg #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           mode_i,
  input  gsa_pkg::ctrl_t                 ctrl_i,
  input  logic signed [DATA_WIDTH-1:0]   sample_i,
  output gsa_pkg::ctrl_t                 ctrl_o,
  output logic [DATA_WIDTH-1:0]          mag_o,
  output logic [gsa_pkg::ARG_W-1:0]      arg_o
);
  import gsa_pkg::*;

  localparam logic [39:0] GeluLim = 40'(16) << FRAC_BITS;
  localparam logic [39:0] SiluLim = 40'(64) << FRAC_BITS;

  ctrl_t c1_q, c2_q, c3_q, c4_q, c5_q;
  logic  md1_q, md2_q, md3_q, md4_q;

  logic [DATA_WIDTH-1:0] m1_q, m2_q, m3_q, m4_q, m5_q;
  logic [XQ_W-1:0]       xq1_q, xq2_q, xq3_q;
  logic [ARG_W-1:0]      ts1_q, ts2_q, ts3_q, ts4_q;
  logic [X2_W-1:0]       x2_q;
  logic [F_W-1:0]        f_q;
  logic [TG_W-1:0]       tg_q;
  logic [ARG_W-1:0]      a_q;

  logic [DATA_WIDTH-1:0] mag_d;
  logic [39:0]           mag_ext, xg, xs;
  logic [XQ_W-1:0]       xq_d;
  logic [ARG_W-1:0]      ts_d, a_d;
  logic [X2_W-1:0]       x2_d;
  logic [F_W-1:0]        f_d;
  logic [TG_W-1:0]       tg_d, tsel;

  always_comb begin
    mag_d   = sample_i[DATA_WIDTH-1] ? (~sample_i + 1'b1) : sample_i;
    mag_ext = 40'(mag_d);
    xg      = (mag_ext > GeluLim) ? GeluLim : mag_ext;
    xs      = (mag_ext > SiluLim) ? SiluLim : mag_ext;
    xq_d    = XQ_W'(64'(xg) << (24 - FRAC_BITS));
    ts_d    = ARG_W'(64'(xs) << (32 - FRAC_BITS));
    x2_d    = X2_W'((58'(xq1_q) * 58'(xq1_q)) >> 24);
    f_d     = C1_Q24 + F_W'((62'(C2_Q32) * 62'(x2_q)) >> 32);
    tg_d    = TG_W'((59'(xq3_q) * 59'(f_q)) >> 16);
    tsel    = (md4_q == MODE_SILU) ? TG_W'(ts4_q) : tg_q;
    a_d     = (tsel > TG_W'(T_MAX)) ? T_MAX : ARG_W'(tsel);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
    end else if (en_i) begin
      c1_q <= ctrl_i;
      c2_q <= c1_q;
      c3_q <= c2_q;
      c4_q <= c3_q;
      c5_q <= c4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      md1_q <= mode_i;
      m1_q  <= mag_d;
      xq1_q <= xq_d;
      ts1_q <= ts_d;
      md2_q <= md1_q;
      m2_q  <= m1_q;
      xq2_q <= xq1_q;
      ts2_q <= ts1_q;
      x2_q  <= x2_d;
      md3_q <= md2_q;
      m3_q  <= m2_q;
      xq3_q <= xq2_q;
      ts3_q <= ts2_q;
      f_q   <= f_d;
      md4_q <= md3_q;
      m4_q  <= m3_q;
      ts4_q <= ts3_q;
      tg_q  <= tg_d;
      m5_q  <= m4_q;
      a_q   <= a_d;
    end
  end

  assign ctrl_o = c5_q;
  assign mag_o  = m5_q;
  assign arg_o  = a_q;

endmodule

### src/gsa_exp.sv
`timescale 1ns / 1ps

module gsa_exp #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  gsa_pkg::ctrl_t             ctrl_i,
  input  logic [DATA_WIDTH-1:0]      mag_i,
  input  logic [gsa_pkg::ARG_W-1:0]  arg_i,
  output gsa_pkg::ctrl_t             ctrl_o,
  output logic [DATA_WIDTH-1:0]      mag_o,
  output logic [gsa_pkg::E_W-1:0]    e_o
);
  import gsa_pkg::*;

  // range reduction: arg = k*ln2 + r
  ctrl_t                 c1_q, c2_q, c3_q, ce_q;
  logic [DATA_WIDTH-1:0] m1_q, m2_q, m3_q, me_q;
  logic [ARG_W-1:0]      a1_q;
  logic [K_W-1:0]        k1_q, k2_q, k3_q;
  logic [33:0]           r0_q;
  logic [R_W-1:0]        r3_q;
  logic [E_W-1:0]        e_q;

  logic [K_W-1:0]   k1_d, k3_d;
  logic [33:0]      r0_d;
  logic [R_W-1:0]   r3_d;
  logic             adj;

  always_comb begin
    k1_d = K_W'((32'(arg_i[ARG_W-1:24]) * 32'(K_RECIP)) >> 24);
    r0_d = 34'(a1_q - ARG_W'(k1_q) * ARG_W'(LN2_Q32));
    adj  = r0_q >= 34'(LN2_Q32);
    k3_d = adj ? k2_q + 1'b1 : k2_q;
    r3_d = R_W'(adj ? r0_q - 34'(LN2_Q32) : r0_q);
  end

  // taylor series of exp(-r), one term every three stages
  ctrl_t                      cm [EXP_TERMS+1];
  logic [DATA_WIDTH-1:0]      mm [EXP_TERMS+1];
  logic [TERM_W-1:0]          tm [EXP_TERMS+1];
  logic signed [SUM_W-1:0]    sm [EXP_TERMS+1];
  logic [K_W-1:0]             km [EXP_TERMS+1];
  logic [R_W-1:0]             rm [EXP_TERMS+1];

  assign cm[0] = c3_q;
  assign mm[0] = m3_q;
  assign tm[0] = TERM_W'(ONE_Q32);
  assign sm[0] = SUM_W'(ONE_Q32);
  assign km[0] = k3_q;
  assign rm[0] = r3_q;

  genvar i;
  for (i = 0; i < EXP_TERMS; i++) begin : g_term
    localparam logic [4:0] Divisor = 5'(i + 1);
    localparam bit         Odd     = (i % 2) == 0;

    ctrl_t                   ca_q, cb_q, cc_q;
    logic [DATA_WIDTH-1:0]   ma_q, mb_q, mc_q;
    logic [TERM_W-1:0]       pa_q, pb_q, qe_q, tc_q;
    logic signed [SUM_W-1:0] sa_q, sb_q, sc_q;
    logic [K_W-1:0]          ka_q, kb_q, kc_q;
    logic [R_W-1:0]          ra_q, rb_q, rc_q;

    logic [TERM_W-1:0]       pa_d, qe_d, q;
    logic [37:0]             rem;
    logic signed [SUM_W-1:0] s_d;

    always_comb begin
      pa_d = TERM_W'((65'(tm[i]) * 65'(rm[i])) >> 32);
      qe_d = TERM_W'((68'(pa_q) * 68'(DIV_MAGIC[i])) >> 34);
      // the reciprocal estimate is at most one short
      rem  = 38'(pb_q) - 38'(qe_q) * 38'(Divisor);
      q    = qe_q + TERM_W'(rem >= 38'(Divisor));
      s_d  = Odd ? sb_q - $signed({2'b00, q}) : sb_q + $signed({2'b00, q});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ca_q <= '0;
        cb_q <= '0;
        cc_q <= '0;
      end else if (en_i) begin
        ca_q <= cm[i];
        cb_q <= ca_q;
        cc_q <= cb_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pa_q <= pa_d;
        ma_q <= mm[i];
        sa_q <= sm[i];
        ka_q <= km[i];
        ra_q <= rm[i];
        pb_q <= pa_q;
        qe_q <= qe_d;
        mb_q <= ma_q;
        sb_q <= sa_q;
        kb_q <= ka_q;
        rb_q <= ra_q;
        tc_q <= q;
        sc_q <= s_d;
        mc_q <= mb_q;
        kc_q <= kb_q;
        rc_q <= rb_q;
      end
    end

    assign cm[i+1] = cc_q;
    assign mm[i+1] = mc_q;
    assign tm[i+1] = tc_q;
    assign sm[i+1] = sc_q;
    assign km[i+1] = kc_q;
    assign rm[i+1] = rc_q;
  end

  logic [E_W-1:0] e_d;

  always_comb begin
    if (km[EXP_TERMS] >= K_LIMIT || sm[EXP_TERMS][SUM_W-1]) begin
      e_d = '0;
    end else begin
      e_d = E_W'(sm[EXP_TERMS][E_W-1:0] >> km[EXP_TERMS]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      ce_q <= '0;
    end else if (en_i) begin
      c1_q <= ctrl_i;
      c2_q <= c1_q;
      c3_q <= c2_q;
      ce_q <= cm[EXP_TERMS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q <= mag_i;
      a1_q <= arg_i;
      k1_q <= k1_d;
      m2_q <= m1_q;
      r0_q <= r0_d;
      k2_q <= k1_q;
      m3_q <= m2_q;
      k3_q <= k3_d;
      r3_q <= r3_d;
      me_q <= mm[EXP_TERMS];
      e_q  <= e_d;
    end
  end

  assign ctrl_o = ce_q;
  assign mag_o  = me_q;
  assign e_o    = e_q;

endmodule

### src/gsa_div.sv
`timescale 1ns / 1ps

module gsa_div #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  gsa_pkg::ctrl_t             ctrl_i,
  input  logic [DATA_WIDTH-1:0]      mag_i,
  input  logic [gsa_pkg::E_W-1:0]    e_i,
  output gsa_pkg::ctrl_t             ctrl_o,
  output logic [DATA_WIDTH-1:0]      mag_o,
  output logic [gsa_pkg::SIG_W-1:0]  sig_o
);
  import gsa_pkg::*;

  localparam int unsigned DW = E_W + 1;

  // rounded sigmoid numerator over d = 1 + e
  logic [DW-1:0] d_d;
  logic [63:0]   num_d;

  always_comb begin
    d_d   = DW'(ONE_Q32) + DW'(e_i);
    num_d = ctrl_i.neg ? (64'(e_i) << 31) + 64'(d_d >> 1)
                       : (64'd1 << 63) + 64'(d_d >> 1);
  end

  ctrl_t                 cs [SIG_W+1];
  logic [DATA_WIDTH-1:0] ms [SIG_W+1];
  logic [DW-1:0]         rs [SIG_W+1];
  logic [DW-1:0]         ds [SIG_W+1];
  logic [SIG_W-1:0]      ls [SIG_W+1];
  logic [SIG_W-1:0]      qs [SIG_W+1];

  ctrl_t                 c0_q;
  logic [DATA_WIDTH-1:0] m0_q;
  logic [DW-1:0]         r0_q, d0_q;
  logic [SIG_W-1:0]      l0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q <= '0;
    end else if (en_i) begin
      c0_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m0_q <= mag_i;
      r0_q <= DW'(num_d[63:32]);
      l0_q <= num_d[31:0];
      d0_q <= d_d;
    end
  end

  assign cs[0] = c0_q;
  assign ms[0] = m0_q;
  assign rs[0] = r0_q;
  assign ds[0] = d0_q;
  assign ls[0] = l0_q;
  assign qs[0] = '0;

  // restoring division, one quotient bit per stage
  genvar i;
  for (i = 0; i < SIG_W; i++) begin : g_bit
    ctrl_t                 c_q;
    logic [DATA_WIDTH-1:0] m_q;
    logic [DW-1:0]         r_q, d_q;
    logic [SIG_W-1:0]      l_q, q_q;

    logic [DW-1:0] trial;
    logic          fits;

    always_comb begin
      trial = {rs[i][DW-2:0], ls[i][SIG_W-1-i]};
      fits  = trial >= ds[i];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        c_q <= '0;
      end else if (en_i) begin
        c_q <= cs[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q <= ms[i];
        r_q <= fits ? trial - ds[i] : trial;
        d_q <= ds[i];
        l_q <= ls[i];
        q_q <= {qs[i][SIG_W-2:0], fits};
      end
    end

    assign cs[i+1] = c_q;
    assign ms[i+1] = m_q;
    assign rs[i+1] = r_q;
    assign ds[i+1] = d_q;
    assign ls[i+1] = l_q;
    assign qs[i+1] = q_q;
  end

  assign ctrl_o = cs[SIG_W];
  assign mag_o  = ms[SIG_W];
  assign sig_o  = qs[SIG_W];

endmodule

### src/gelu_silu_activation.sv
`timescale 1ns / 1ps
// throughput: one word per cycle unless the output stalls; 5 argument stages, 52 exp
// stages (three per taylor term), 33 divider stages (a setup stage, then one quotient
// bit each), 2 scale and round stages
// a stalled output freezes the whole pipeline, so in_ch.ready is low only while a held result waits on out_ch.ready
// reset clears all valid bits and sets mode to gelu; data registers are not reset
module gelu_silu_activation #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gsa_in_if.sink      in_ch,
  gsa_out_if.source   out_ch,
  input  logic        mode_we_i,
  input  logic        mode_wdata_i
);
  import gsa_pkg::*;

  localparam int unsigned ProdW = DATA_WIDTH + SIG_W;
  localparam int unsigned RW    = DATA_WIDTH + 1;
  localparam logic [RW-1:0] NegMax = RW'(64'd1 << (DATA_WIDTH - 1));
  localparam logic [RW-1:0] PosMax = NegMax - 1'b1;

  logic  mode_q;
  logic  en;
  ctrl_t in_ctrl;

  ctrl_t                 arg_ctrl, exp_ctrl, div_ctrl;
  logic [DATA_WIDTH-1:0] arg_mag, exp_mag, div_mag;
  logic [ARG_W-1:0]      arg;
  logic [E_W-1:0]        e;
  logic [SIG_W-1:0]      sig;

  ctrl_t                        prod_ctrl_q, out_ctrl_q;
  logic [ProdW-1:0]             prod_q;
  logic signed [DATA_WIDTH-1:0] act_q;

  logic [ProdW:0]               rnd;
  logic [RW-1:0]                rmag, rsat;
  logic signed [DATA_WIDTH-1:0] act_d;

  assign en       = !out_ctrl_q.valid || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    in_ctrl.valid = in_ch.valid;
    in_ctrl.last  = in_ch.last_in;
    in_ctrl.neg   = in_ch.sample[DATA_WIDTH-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_GELU;
    end else if (mode_we_i) begin
      mode_q <= mode_wdata_i;
    end
  end

  gsa_arg #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_arg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .mode_i  (mode_q),
    .ctrl_i  (in_ctrl),
    .sample_i(in_ch.sample),
    .ctrl_o  (arg_ctrl),
    .mag_o   (arg_mag),
    .arg_o   (arg)
  );

  gsa_exp #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_exp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .ctrl_i(arg_ctrl),
    .mag_i (arg_mag),
    .arg_i (arg),
    .ctrl_o(exp_ctrl),
    .mag_o (exp_mag),
    .e_o   (e)
  );

  gsa_div #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .ctrl_i(exp_ctrl),
    .mag_i (exp_mag),
    .e_i   (e),
    .ctrl_o(div_ctrl),
    .mag_o (div_mag),
    .sig_o (sig)
  );

  // round half away from zero on the magnitude, then saturate and sign
  always_comb begin
    rnd   = (ProdW + 1)'(prod_q) + (ProdW + 1)'(64'd1 << 30);
    rmag  = RW'(rnd >> 31);
    if (prod_ctrl_q.neg) begin
      rsat  = (rmag > NegMax) ? NegMax : rmag;
      act_d = DATA_WIDTH'(RW'(0) - rsat);
    end else begin
      rsat  = (rmag > PosMax) ? PosMax : rmag;
      act_d = DATA_WIDTH'(rsat);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_ctrl_q <= '0;
      out_ctrl_q  <= '0;
    end else if (en) begin
      prod_ctrl_q <= div_ctrl;
      out_ctrl_q  <= prod_ctrl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= ProdW'(div_mag) * ProdW'(sig);
      act_q  <= act_d;
    end
  end

  assign out_ch.valid     = out_ctrl_q.valid;
  assign out_ch.activated = act_q;
  assign out_ch.last_out  = out_ctrl_q.last;

`ifndef SYNTHESIS
  a_neg_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ctrl_q.valid && out_ctrl_q.neg) |-> (act_q[DATA_WIDTH-1] || act_q == '0))
    else $error("negative word gave a positive result");

  a_pos_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ctrl_q.valid && !out_ctrl_q.neg) |-> !act_q[DATA_WIDTH-1])
    else $error("positive word gave a negative result");

  a_sig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctrl.valid |-> (sig <= 32'h8000_0000))
    else $error("sigmoid above one");

  // bubbles carry undefined data, so only a valid product is checked
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(prod_ctrl_q) && (!prod_ctrl_q.valid || $stable(prod_q))))
    else $error("pipeline moved during a stall");
`endif

endmodule

### sim/gsa_checker.sv
`timescale 1ns / 1ps

module gsa_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [15:0] sample_i,
  input  logic        last_in_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] activated_i,
  input  logic        last_out_i,
  input  logic        mode_we_i,
  input  logic        mode_wdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  import gsa_pkg::*;

  localparam logic [63:0] LN2  = 64'd2977044472;
  localparam logic [63:0] ONE  = 64'd4294967296;
  localparam logic [63:0] C1   = (64'd6853776189 + 64'd128) >> 8;
  localparam logic [63:0] C2   = 64'd306466602;

  typedef struct packed {
    logic [15:0] activated;
    logic        last_out;
  } word_t;

  word_t expected_q[$];
  logic  mode_q;

  function automatic logic [63:0] exp_neg(input logic [63:0] a);
    logic [63:0]  k, r, term;
    logic [127:0] prod;
    longint       sum;
    k = a / LN2;
    r = a - k * LN2;
    term = ONE;
    sum = longint'(ONE);
    if (k >= 40) return 64'd0;
    for (int n = 1; n <= 16; n++) begin
      prod = 128'(term) * 128'(r);
      term = 64'(prod >> 32) / 64'(n);
      if (n % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    return 64'(sum) >> k;
  endfunction

  function automatic word_t activate(input logic m, input logic [15:0] x, input logic lst);
    logic         neg;
    logic [63:0]  mag, xm, xq, x2, f, t, e, d, s, r;
    logic [127:0] prod;
    word_t        w;
    neg = x[15];
    mag = neg ? 64'((~{48'd0, x} + 64'd1) & 64'hffff) : {48'd0, x};
    if (m == MODE_GELU) begin
      xm = (mag > (64'd16 << 12)) ? (64'd16 << 12) : mag;
      xq = xm << 12;
      x2 = (xq * xq) >> 24;
      prod = 128'(C2) * 128'(x2);
      f = C1 + 64'(prod >> 32);
      prod = 128'(xq) * 128'(f);
      t = 64'(prod >> 16);
    end else begin
      xm = (mag > (64'd64 << 12)) ? (64'd64 << 12) : mag;
      t = xm << 20;
    end
    if (t > (64'd64 << 32)) t = 64'd64 << 32;
    e = exp_neg(t);
    d = ONE + e;
    if (!neg) s = ((64'd1 << 63) + (d >> 1)) / d;
    else s = ((e << 31) + (d >> 1)) / d;
    r = (mag * s + (64'd1 << 30)) >> 31;
    if (!neg) begin
      if (r > 64'd32767) r = 64'd32767;
      w.activated = r[15:0];
    end else begin
      if (r > 64'd32768) r = 64'd32768;
      w.activated = 16'(64'd0 - r);
    end
    w.last_out = lst;
    return w;
  endfunction

  assign pending_o = expected_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    word_t w;
    int    errs;
    if (!rst_ni) begin
      mode_q <= MODE_GELU;
      fail_count_o <= 0;
    end else begin
      errs = 0;
      if (mode_we_i) mode_q <= mode_wdata_i;
      if (in_valid_i && in_ready_i)
        expected_q.push_back(activate(mode_q, sample_i, last_in_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected word activated=%h", activated_i);
          errs = errs + 1;
        end else begin
          w = expected_q.pop_front();
          if (w.activated !== activated_i) begin
            $error("activated: expected %h actual %h", w.activated, activated_i);
            errs = errs + 1;
          end
          if (w.last_out !== last_out_i) begin
            $error("last_out: expected %b actual %b", w.last_out, last_out_i);
            errs = errs + 1;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import gsa_pkg::*;

  localparam int   LATENCY   = 92;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic mode_we_i = 1'b0;
  logic mode_wdata_i = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   fail_count, pending;

  gsa_in_if  #(.DATA_WIDTH(16)) in_ch ();
  gsa_out_if #(.DATA_WIDTH(16)) out_ch ();

  always #10 clk_i = ~clk_i;

  gelu_silu_activation #(.DATA_WIDTH(16), .FRAC_BITS(12)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .mode_we_i(mode_we_i), .mode_wdata_i(mode_wdata_i)
  );

  gsa_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready),
    .sample_i(in_ch.sample), .last_in_i(in_ch.last_in),
    .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready),
    .activated_i(out_ch.activated), .last_out_i(out_ch.last_out),
    .mode_we_i(mode_we_i), .mode_wdata_i(mode_wdata_i),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.last_in = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i)
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

  // sends one word, with a random gap before it
  task automatic send_word(input logic [15:0] x, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= x;
    in_ch.last_in <= lst;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    mode_we_i <= 1'b1;
    mode_wdata_i <= m;
    @(posedge clk_i);
    mode_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] random_sample();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'(($signed($urandom_range(32767)) >>> $urandom_range(15)) *
                    ($urandom_range(1) ? 1 : -1));
      2: return 16'(int'($urandom_range(8 << 12)) - (4 << 12));
      default: return 16'(int'($urandom_range(32)) - 16);
    endcase
  endfunction

  task automatic directed(input logic m);
    logic [15:0] corner[] = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000,
      16'h8001, 16'h1000, 16'hf000, 16'h4000, 16'hc000, 16'h5555, 16'haaaa};
    write_mode(m);
    foreach (corner[i]) send_word(corner[i], 1'(i % 2));
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed(MODE_SILU);
    directed(MODE_GELU);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 56 : 0;
      recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 33 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        write_mode(1'($urandom_range(1)));
        for (int i = 0; i < 150; i++) send_word(random_sample(), 1'($urandom_range(1)));
        // hold the sender until the pipeline is empty
        drain();
        repeat (LATENCY) @(posedge clk_i);
      end
    end
    drain();
    repeat (LATENCY + 8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
